### hdl/bida_pkg.sv
package bida_pkg;

	// Default geometry of the id store.
	localparam int NUM_WORDS_DEF = 64;
	localparam int WORD_BITS_DEF = 32;

	// Fixed widths of the request and result fields.
	localparam int ID_W     = 11;
	localparam int STATUS_W = 3;

	// Shift used by the reciprocal that splits an id into word and bit.
	localparam int DIV_SHIFT = 18;

	// Request kinds.
	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_ZERO  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FREE  = 3'd4;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DEC,
		S_RD,
		S_SCAN
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

### hdl/bida_mem.sv
module bida_mem #(
	parameter int NUM_WORDS = bida_pkg::NUM_WORDS_DEF,
	parameter int WORD_BITS = bida_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  bida_pkg::mem_ctl_t           ctl,
	input  logic [$clog2(NUM_WORDS)-1:0] waddr,
	input  logic [WORD_BITS-1:0]         wdata,
	input  logic [$clog2(NUM_WORDS)-1:0] raddr,
	output logic [WORD_BITS-1:0]         rdata
);

	// One write port and one read port; the read is registered, so read data appears in the cycle after the address.
	logic [WORD_BITS-1:0] mem [NUM_WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/bida_ctrl.sv
module bida_ctrl #(
	parameter int NUM_WORDS = bida_pkg::NUM_WORDS_DEF,
	parameter int WORD_BITS = bida_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             req_type,
	input  logic [bida_pkg::ID_W-1:0]        release_id,
	output logic                             done,
	output logic [bida_pkg::ID_W-1:0]        granted_id,
	output logic [bida_pkg::STATUS_W-1:0]    status,
	output bida_pkg::mem_ctl_t               mem_ctl,
	output logic [$clog2(NUM_WORDS)-1:0]     waddr,
	output logic [WORD_BITS-1:0]             wdata,
	output logic [$clog2(NUM_WORDS)-1:0]     raddr,
	input  logic [WORD_BITS-1:0]             rdata
);

	localparam int AW    = $clog2(NUM_WORDS);
	localparam int LW    = $clog2(NUM_WORDS + 1);
	localparam int BW    = $clog2(WORD_BITS);
	localparam int IW    = bida_pkg::ID_W;
	localparam int PW    = bida_pkg::ID_W + bida_pkg::DIV_SHIFT;
	localparam int RECIP = ((1 << bida_pkg::DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;

	bida_pkg::state_t state_q, state_d;

	logic [LW-1:0]                  lfw_q, lfw_d;
	logic [AW-1:0]                  ptr_q, ptr_d;
	logic                           done_q, done_d;
	logic                           op_q, op_d;
	logic [IW-1:0]                  rid_q, rid_d;
	logic [IW-1:0]                  quo_q, quo_d;
	logic [IW-1:0]                  gid_q, gid_d;
	logic [bida_pkg::STATUS_W-1:0]  stat_q, stat_d;

	logic [PW-1:0]        prod_c;
	logic [IW-1:0]        quo_c;
	logic                 range_bad;
	logic [IW-1:0]        rem_c;
	logic [BW-1:0]        bit_c;
	logic [WORD_BITS-1:0] inv_c;
	logic [WORD_BITS-1:0] iso_c;
	logic [WORD_BITS-1:0] new_word;
	logic [BW-1:0]        bpos_c;
	logic [IW-1:0]        gid_c;
	logic                 rd_full;
	logic                 new_full;
	logic                 ptr_last;
	logic                 lfw_none;
	logic [AW-1:0]        ptr_inc;

	// Shared decode of the registered state and the memory read data.
	always_comb begin : decode
		prod_c    = PW'(rid_q) * PW'(RECIP);
		quo_c     = IW'(prod_c >> bida_pkg::DIV_SHIFT);
		range_bad = (32'(quo_c) >= 32'(NUM_WORDS));
		rem_c     = rid_q - IW'(quo_q * IW'(WORD_BITS));
		bit_c     = BW'(rem_c);
		inv_c     = ~rdata;
		iso_c     = inv_c & (~inv_c + WORD_BITS'(1));
		new_word  = rdata | iso_c;
		bpos_c    = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (iso_c[i]) begin
				bpos_c = BW'(i);
			end
		end
		gid_c     = IW'(32'(ptr_q) * 32'(WORD_BITS) + 32'(bpos_c));
		rd_full   = &rdata;
		new_full  = &new_word;
		ptr_last  = (ptr_q == AW'(NUM_WORDS - 1));
		lfw_none  = (lfw_q == LW'(NUM_WORDS));
		ptr_inc   = ptr_q + AW'(1);
	end

	always_comb begin : next_state
		state_d = state_q;
		unique case (state_q)
			bida_pkg::S_CLEAR: begin
				if (ptr_last) begin
					state_d = bida_pkg::S_IDLE;
				end
			end
			bida_pkg::S_IDLE: begin
				if (start) begin
					if (req_type == bida_pkg::REQ_ALLOC) begin
						if (!lfw_none) begin
							state_d = bida_pkg::S_RD;
						end
					end else if (release_id != '0) begin
						state_d = bida_pkg::S_DEC;
					end
				end
			end
			bida_pkg::S_DEC: begin
				state_d = range_bad ? bida_pkg::S_IDLE : bida_pkg::S_RD;
			end
			bida_pkg::S_RD: begin
				if (op_q == bida_pkg::REQ_ALLOC && (rd_full || (new_full && !ptr_last))) begin
					state_d = bida_pkg::S_SCAN;
				end else begin
					state_d = bida_pkg::S_IDLE;
				end
			end
			bida_pkg::S_SCAN: begin
				if (!rd_full || ptr_last) begin
					state_d = bida_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bida_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin : actions
		mem_ctl = '0;
		waddr   = ptr_q;
		wdata   = '0;
		raddr   = ptr_q;
		ptr_d   = ptr_q;
		lfw_d   = lfw_q;
		done_d  = 1'b0;
		op_d    = op_q;
		rid_d   = rid_q;
		quo_d   = quo_q;
		gid_d   = gid_q;
		stat_d  = stat_q;
		unique case (state_q)
			bida_pkg::S_CLEAR: begin
				mem_ctl.wr_en = 1'b1;
				wdata         = (ptr_q == '0) ? WORD_BITS'(1) : '0;
				ptr_d         = ptr_inc;
			end
			bida_pkg::S_IDLE: begin
				if (start) begin
					op_d  = req_type;
					rid_d = release_id;
					gid_d = '0;
					if (req_type == bida_pkg::REQ_ALLOC) begin
						if (lfw_none) begin
							done_d = 1'b1;
							stat_d = bida_pkg::STAT_FULL;
						end else begin
							mem_ctl.rd_en = 1'b1;
							raddr         = AW'(lfw_q);
							ptr_d         = AW'(lfw_q);
						end
					end else if (release_id == '0) begin
						done_d = 1'b1;
						stat_d = bida_pkg::STAT_ZERO;
					end
				end
			end
			bida_pkg::S_DEC: begin
				quo_d = quo_c;
				if (range_bad) begin
					done_d = 1'b1;
					stat_d = bida_pkg::STAT_RANGE;
				end else begin
					mem_ctl.rd_en = 1'b1;
					raddr         = AW'(quo_c);
					ptr_d         = AW'(quo_c);
				end
			end
			bida_pkg::S_RD: begin
				done_d = 1'b1;
				if (op_q == bida_pkg::REQ_ALLOC) begin
					if (rd_full) begin
						// The word was full after all: answer full and rescan from it.
						stat_d        = bida_pkg::STAT_FULL;
						mem_ctl.rd_en = 1'b1;
					end else begin
						mem_ctl.wr_en = 1'b1;
						wdata         = new_word;
						stat_d        = bida_pkg::STAT_OK;
						gid_d         = gid_c;
						if (new_full) begin
							if (ptr_last) begin
								lfw_d = LW'(NUM_WORDS);
							end else begin
								mem_ctl.rd_en = 1'b1;
								raddr         = ptr_inc;
								ptr_d         = ptr_inc;
							end
						end
					end
				end else if (!rdata[bit_c]) begin
					stat_d = bida_pkg::STAT_FREE;
				end else begin
					mem_ctl.wr_en = 1'b1;
					wdata         = rdata & ~(WORD_BITS'(1) << bit_c);
					stat_d        = bida_pkg::STAT_OK;
					if (LW'(ptr_q) < lfw_q) begin
						lfw_d = LW'(ptr_q);
					end
				end
			end
			bida_pkg::S_SCAN: begin
				if (!rd_full) begin
					lfw_d = LW'(ptr_q);
				end else if (ptr_last) begin
					lfw_d = LW'(NUM_WORDS);
				end else begin
					mem_ctl.rd_en = 1'b1;
					raddr         = ptr_inc;
					ptr_d         = ptr_inc;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bida_pkg::S_CLEAR;
			lfw_q   <= '0;
			ptr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			lfw_q   <= lfw_d;
			ptr_q   <= ptr_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		rid_q  <= rid_d;
		quo_q  <= quo_d;
		gid_q  <= gid_d;
		stat_q <= stat_d;
	end

	assign busy       = (state_q != bida_pkg::S_IDLE);
	assign done       = done_q;
	assign granted_id = gid_q;
	assign status     = stat_q;

endmodule

### hdl/bitmap_id_allocator.sv
// Channel  | Signals                           | Transfer
// ---------+-----------------------------------+--------------------------------------
// request  | start, busy, req_type, release_id | rising edge with start high, busy low
// result   | done, granted_id, status          | rising edge ending the cycle done is high
//
// An allocate holds busy through S_RD after its transfer, a release through S_DEC and S_RD (S_DEC
// alone if the id is out of range); the result follows in the cycle after the last of these states,
// and no new request is taken while busy is high. A release of id 0 or an allocate with every id
// taken is answered without leaving idle. An allocate that fills a word other than the last
// starts a scan through the bitmap memory read port, one word per cycle, busy high past the result.
// After reset the block clears the bitmap memory with busy held high; the receiver cannot stall.
module bitmap_id_allocator #(
	parameter int NUM_WORDS = bida_pkg::NUM_WORDS_DEF,
	parameter int WORD_BITS = bida_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [bida_pkg::ID_W-1:0]     release_id,
	output logic                          done,
	output logic [bida_pkg::ID_W-1:0]     granted_id,
	output logic [bida_pkg::STATUS_W-1:0] status
);

	localparam int AW = $clog2(NUM_WORDS);

	// The bitmap lives in a single memory with one write and one read port. Each word
	// holds WORD_BITS ids, a set bit meaning the id is taken. The controller reads a word,
	// modifies it and writes it back in the following cycle; a scan for the next word
	// with a free id streams reads through the same port, one word per cycle.
	bida_pkg::mem_ctl_t   mem_ctl;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	// The controller holds the index of the lowest word with a free id, splits a
	// released id into word and bit with a reciprocal multiplication, and runs the
	// clearing pass that follows reset. Word 0 is written with its lowest bit set so
	// that id 0 is never handed out.
	bida_ctrl #(
		.NUM_WORDS(NUM_WORDS),
		.WORD_BITS(WORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.release_id(release_id),
		.done      (done),
		.granted_id(granted_id),
		.status    (status),
		.mem_ctl   (mem_ctl),
		.waddr     (mem_waddr),
		.wdata     (mem_wdata),
		.raddr     (mem_raddr),
		.rdata     (mem_rdata)
	);

	// Accesses never collide: a write goes to the word just read, while any read in
	// the same cycle goes to the word above it, so no forwarding is needed.
	bida_mem #(
		.NUM_WORDS(NUM_WORDS),
		.WORD_BITS(WORD_BITS)
	) u_mem (
		.clk  (clk),
		.ctl  (mem_ctl),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

### hdl/bida_checker.sv
module bida_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          req_type,
	input logic                          done,
	input logic [bida_pkg::ID_W-1:0]     granted_id,
	input logic [bida_pkg::STATUS_W-1:0] status
);

	// Kind of the request whose result is outstanding.
	logic last_req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_req_q <= bida_pkg::REQ_ALLOC;
		end else if (start && !busy) begin
			last_req_q <= req_type;
		end
	end

	a_fail_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != bida_pkg::STAT_OK |-> granted_id == '0)
		else $error("failed request returned a non-zero id");

	a_transfer_answered: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("request transfer neither started work nor gave a result");

	a_alloc_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && last_req_q == bida_pkg::REQ_ALLOC |->
			status == bida_pkg::STAT_OK || status == bida_pkg::STAT_FULL)
		else $error("allocate answered with a release status");

	a_release_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && last_req_q == bida_pkg::REQ_RELEASE |-> granted_id == '0)
		else $error("release returned an id");

endmodule

bind bitmap_id_allocator bida_checker u_bida_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.req_type  (req_type),
	.done      (done),
	.granted_id(granted_id),
	.status    (status)
);
